>>> src/tcw_pkg.sv
// Package for the text console writer: payload structs, command codes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Coordinates are compared at this width so any legal COLUMNS or ROWS fits.
   localparam int COORD_W = 9;

   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   typedef enum logic [2:0] {
      ACT_CHAR       = 3'd0,
      ACT_COLOR_CHAR = 3'd1,
      ACT_NEWLINE    = 3'd2,
      ACT_BACKSPACE  = 3'd3,
      ACT_CLEAR      = 3'd4,
      ACT_SET_POS    = 3'd5,
      ACT_READ       = 3'd6
   } action_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] char_code;
      logic [3:0] fore_colour;
      logic [3:0] back_colour;
      logic [6:0] column;
      logic [4:0] row;
   } req_item_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attribute;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_RD_WAIT,
      ST_CLEAR,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK
   } state_type;

   typedef struct packed {
      logic load_req;     // latch the accepted item
      logic exec;         // perform the latched action
      logic ptr_clear;    // sweep pointer back to cell 0
      logic ptr_inc;      // advance the sweep pointer
      logic fill;         // write a blank cell at the sweep pointer
      logic fill_reset;   // the blank uses the reset attribute
      logic copy_read;    // read the cell one row below the sweep pointer
      logic scroll_done;  // cursor to the start of the bottom row
      logic cursor_home;  // cursor to cell 0
      logic respond;      // present a result next cycle
      logic respond_read; // the result carries the read cell
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       need_room;
      logic       ptr_copy_last;
      logic       ptr_last;
   } ctrl_status_type;

endpackage

>>> src/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg.
module tcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tcw_pkg::ctrl_status_type status,
   output tcw_pkg::ctrl_cmd_type    cmd
);

   tcw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (status.ptr_last) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (start) state_in = tcw_pkg::ST_EXEC;
         end
         tcw_pkg::ST_EXEC: begin
            case (status.action)
               tcw_pkg::ACT_CHAR, tcw_pkg::ACT_COLOR_CHAR, tcw_pkg::ACT_NEWLINE: begin
                  state_in = status.need_room ? tcw_pkg::ST_COPY : tcw_pkg::ST_IDLE;
               end
               tcw_pkg::ACT_CLEAR: state_in = tcw_pkg::ST_CLEAR;
               tcw_pkg::ACT_READ:  state_in = tcw_pkg::ST_RD_WAIT;
               default:            state_in = tcw_pkg::ST_IDLE;
            endcase
         end
         tcw_pkg::ST_RD_WAIT: state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_CLEAR: begin
            if (status.ptr_last) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_COPY: begin
            if (status.ptr_copy_last) state_in = tcw_pkg::ST_DRAIN;
         end
         tcw_pkg::ST_DRAIN: state_in = tcw_pkg::ST_BLANK;
         tcw_pkg::ST_BLANK: begin
            if (status.ptr_last) state_in = tcw_pkg::ST_EXEC;
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            cmd.fill       = 1'b1;
            cmd.fill_reset = 1'b1;
            cmd.ptr_inc    = ~status.ptr_last;
         end
         tcw_pkg::ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         tcw_pkg::ST_EXEC: begin
            case (status.action)
               tcw_pkg::ACT_CHAR, tcw_pkg::ACT_COLOR_CHAR, tcw_pkg::ACT_NEWLINE: begin
                  if (status.need_room) begin
                     cmd.ptr_clear = 1'b1;
                  end else begin
                     cmd.exec    = 1'b1;
                     cmd.respond = 1'b1;
                  end
               end
               tcw_pkg::ACT_CLEAR: cmd.ptr_clear = 1'b1;
               tcw_pkg::ACT_READ:  cmd.exec      = 1'b1;
               default: begin
                  cmd.exec    = 1'b1;
                  cmd.respond = 1'b1;
               end
            endcase
         end
         tcw_pkg::ST_RD_WAIT: begin
            cmd.respond      = 1'b1;
            cmd.respond_read = 1'b1;
         end
         tcw_pkg::ST_CLEAR: begin
            cmd.fill = 1'b1;
            if (status.ptr_last) begin
               cmd.cursor_home = 1'b1;
               cmd.respond     = 1'b1;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         tcw_pkg::ST_COPY: begin
            cmd.copy_read = 1'b1;
            cmd.ptr_inc   = 1'b1;
         end
         tcw_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         tcw_pkg::ST_BLANK: begin
            cmd.fill = 1'b1;
            if (status.ptr_last) begin
               cmd.scroll_done = 1'b1;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> src/tcw_dpath.sv
// Datapath of the text console writer: cell memory, cursor, sweep pointer,
// attribute register and result register. Depends on tcw_pkg.
module tcw_dpath #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::req_item_type    req_item,
   input  logic                     csr_write_enable,
   input  logic [7:0]               csr_write_data,
   input  tcw_pkg::ctrl_cmd_type    cmd,
   output tcw_pkg::ctrl_status_type status,
   output logic                     rsp_valid,
   output tcw_pkg::rsp_item_type    rsp_item
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS + 1);
   localparam int MAW   = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int XW    = tcw_pkg::COORD_W;

   logic [15:0] mem [CELLS];

   tcw_pkg::req_item_type req_ff;
   tcw_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic [7:0]            attr_ff;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [MAW-1:0]        ptr_ff, ptr_in;
   logic [15:0]           rd_data_ff;
   logic                  copy_vld_ff;
   logic [MAW-1:0]        copy_addr_ff;

   logic                  wr_en;
   logic [MAW-1:0]        wr_addr;
   logic [15:0]           wr_data;
   logic [MAW-1:0]        rd_addr;
   logic [CW-1:0]         col_sat;
   logic [RW-1:0]         row_sat;
   logic [AW-1:0]         cell_idx;
   logic [AW-1:0]         cursor_m1;
   logic [7:0]            blank_attr;

   // Saturated cell index of the latched column and row.
   always_comb begin
      col_sat = (XW'(req_ff.column) >= XW'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(req_ff.column);
      row_sat = (XW'(req_ff.row) >= XW'(ROWS)) ? RW'(ROWS - 1) : RW'(req_ff.row);
      cell_idx = AW'(row_sat) * AW'(COLUMNS) + AW'(col_sat);
   end

   assign cursor_m1  = cursor_ff - AW'(1);
   assign blank_attr = cmd.fill_reset ? tcw_pkg::RESET_ATTR : attr_ff;

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = {blank_attr, tcw_pkg::BLANK_CHAR};
      rd_addr   = cell_idx[MAW-1:0];

      if (copy_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_addr_ff;
         wr_data = rd_data_ff;
      end
      if (cmd.fill) begin
         wr_en = 1'b1;
      end
      if (cmd.copy_read) begin
         rd_addr = ptr_ff + MAW'(COLUMNS);
      end
      if (cmd.exec) begin
         case (tcw_pkg::action_type'(req_ff.action))
            tcw_pkg::ACT_CHAR, tcw_pkg::ACT_COLOR_CHAR: begin
               wr_en   = 1'b1;
               wr_addr = cursor_ff[MAW-1:0];
               if (req_ff.action == tcw_pkg::ACT_CHAR) begin
                  wr_data = {attr_ff, req_ff.char_code};
               end else begin
                  wr_data = {req_ff.back_colour, req_ff.fore_colour, req_ff.char_code};
               end
               cursor_in = cursor_ff + AW'(1);
               col_in    = (col_ff == CW'(COLUMNS - 1)) ? '0 : col_ff + CW'(1);
            end
            tcw_pkg::ACT_NEWLINE: begin
               cursor_in = cursor_ff + AW'(COLUMNS) - AW'(col_ff);
               col_in    = '0;
            end
            tcw_pkg::ACT_BACKSPACE: begin
               if (cursor_ff != '0) begin
                  wr_en     = 1'b1;
                  wr_addr   = cursor_m1[MAW-1:0];
                  wr_data   = {attr_ff, tcw_pkg::BLANK_CHAR};
                  cursor_in = cursor_m1;
                  col_in    = (col_ff == '0) ? CW'(COLUMNS - 1) : col_ff - CW'(1);
               end
            end
            tcw_pkg::ACT_SET_POS: begin
               cursor_in = cell_idx;
               col_in    = col_sat;
            end
            default: begin
               cursor_in = cursor_ff;
            end
         endcase
      end
      if (cmd.scroll_done) begin
         cursor_in = AW'(CELLS - COLUMNS);
         col_in    = '0;
      end
      if (cmd.cursor_home) begin
         cursor_in = '0;
         col_in    = '0;
      end
   end

   always_comb begin
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + MAW'(1);
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_comb begin
      rsp_in.cursor_position = 11'(cursor_in);
      rsp_in.cell_char       = cmd.respond_read ? rd_data_ff[7:0] : 8'd0;
      rsp_in.cell_attribute  = cmd.respond_read ? rd_data_ff[15:8] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tcw_pkg::RESET_ATTR;
         cursor_ff    <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         copy_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         copy_vld_ff  <= cmd.copy_read;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= ptr_ff;
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      status.action        = tcw_pkg::action_type'(req_ff.action);
      status.need_room     = (cursor_ff >= AW'(CELLS));
      status.ptr_copy_last = (ptr_ff == MAW'(CELLS - COLUMNS - 1));
      status.ptr_last      = (ptr_ff == MAW'(CELLS - 1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> src/text_console_writer_unit.sv
// Top level of the text console writer: a COLUMNS x ROWS character store with cursor.
// Depends on tcw_pkg, tcw_ctrl and tcw_dpath.
//
//   Channel   Ports                                  Transfer
//   -------   -------------------------------------  ------------------------------
//   command   start, busy, req_item                  item taken when start && !busy
//   result    rsp_valid, rsp_item                    one-cycle strobe, always taken
//   config    csr_write_enable, csr_write_data       written when enable is high
//
// Plain character, newline, backspace and set position respond from the execute state;
// a cell read adds a wait state for the registered memory read port. Clear sweeps all cells.
// A write or newline past the end first scrolls one cell per cycle (copy, a drain step,
// blank the bottom row, run the item again).
// The next item is accepted in the strobe cycle; results are never held off.
// After reset the store is swept to blanks with busy held high.
module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tcw_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output tcw_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data
);

   // The controller sequences each item; the datapath owns all storage.
   tcw_pkg::ctrl_cmd_type    cmd;
   tcw_pkg::ctrl_status_type status;

   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tcw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

endmodule
